// File: rtl/hsfe_pkg.sv
// shared constants and types for the header sync frame extractor
package hsfe_pkg;

	localparam int WINDOW_DEPTH_DEF = 64;
	localparam int FRAME_BYTES_DEF  = 39;
	localparam int IDX_W            = 6;

	localparam logic [7:0] SH_HEAD0 = 8'hA5;
	localparam logic [7:0] SH_HEAD1 = 8'h1E;
	localparam logic [7:0] DH_HEAD0 = 8'h52;
	localparam logic [7:0] DH_HEAD1 = 8'h8C;
	localparam logic [7:0] DH_MID0  = 8'hA9;
	localparam logic [7:0] DH_MID1  = 8'h53;
	localparam int         DH_TAIL  = 17;
	localparam int         DH_EMPTY_LEN = 4 + DH_TAIL;

	localparam logic MODE_SINGLE = 1'b0;
	localparam logic MODE_DUAL   = 1'b1;

	localparam logic OP_DATA   = 1'b0;
	localparam logic OP_RESYNC = 1'b1;

	// one byte of an extracted frame, handed from the sequencer to the output stage
	typedef struct packed {
		logic [7:0]       frame_byte;
		logic [IDX_W-1:0] byte_index;
		logic             last;
	} emit_t;

endpackage

// File: rtl/header_sync_frame_extractor_core.sv
// Header sync frame extractor: byte-serial deframer over a window memory.
// Input channel (in_valid/in_stall) carries one item per received byte, or a
// resync that empties the window. Output channel (out_valid/out_stall) carries
// frame bytes with their index and a last flag on the final byte.
// frame_mode is written through cfg_we/cfg_wdata; the user must write it only
// while the block is idle, and the block itself does not enforce this. Values:
// 0 single-header frames (A5 1E, FRAME_BYTES bytes emitted whole),
// 1 dual-header packets (52 8C, payload, A9 53, 17 trailing bytes).
// A data item is accepted and written into the window, then the scan reads
// window bytes from memory one at a time and compares them, until it stops
// short of bytes or emits; a failed header check drops the oldest byte and the
// scan starts over. A resync item is handled while idle, without a write.
// An emitted frame is read out byte by byte once the header checks finish,
// each byte a memory read and then a load into the output register.
// A stall on the output holds the output register and pauses the readout;
// a new input item may be taken while the final byte still waits.
// Reset empties the window and selects single-header mode; the window memory
// needs no clearing pass since a slot's data is only used once it is written.
module header_sync_frame_extractor_core import hsfe_pkg::*; #(
	parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF,
	parameter int FRAME_BYTES  = FRAME_BYTES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic             cfg_wdata,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic             opcode,
	input  logic [7:0]       data_byte,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [7:0]       frame_byte,
	output logic [IDX_W-1:0] byte_index,
	output logic             last
);

	localparam int AW = $clog2(WINDOW_DEPTH);

	logic          frame_mode_q;
	logic          out_valid_q;
	emit_t         out_q;
	logic          busy;
	logic          out_free;
	logic          emit_valid;
	emit_t         emit;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [7:0]    mem_wdata;
	logic          mem_re;
	logic [AW-1:0] mem_raddr;
	logic [7:0]    mem_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_mode_q <= MODE_SINGLE;
		end else if (cfg_we) begin
			frame_mode_q <= cfg_wdata;
		end
	end

	// output register frees this cycle if empty or being taken
	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_valid) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_valid) begin
			out_q <= emit;
		end
	end

	assign in_stall   = busy;
	assign out_valid  = out_valid_q;
	assign frame_byte = out_q.frame_byte;
	assign byte_index = out_q.byte_index;
	assign last       = out_q.last;

	hsfe_seq #(
		.WINDOW_DEPTH (WINDOW_DEPTH),
		.FRAME_BYTES  (FRAME_BYTES),
		.AW           (AW)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.frame_mode (frame_mode_q),
		.in_valid   (in_valid),
		.opcode     (opcode),
		.data_byte  (data_byte),
		.busy       (busy),
		.out_free   (out_free),
		.emit_valid (emit_valid),
		.emit       (emit),
		.mem_we     (mem_we),
		.mem_waddr  (mem_waddr),
		.mem_wdata  (mem_wdata),
		.mem_re     (mem_re),
		.mem_raddr  (mem_raddr),
		.mem_rdata  (mem_rdata)
	);

	hsfe_win_mem #(
		.WINDOW_DEPTH (WINDOW_DEPTH),
		.AW           (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

endmodule

// File: rtl/hsfe_win_mem.sv
// byte window memory, one write port and one registered read port
module hsfe_win_mem import hsfe_pkg::*; #(
	parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF,
	parameter int AW = $clog2(WINDOW_DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);

	logic [7:0] mem [WINDOW_DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: rtl/hsfe_seq.sv
// window sequencer: append, header scan, drops and frame readout
module hsfe_seq import hsfe_pkg::*; #(
	parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF,
	parameter int FRAME_BYTES  = FRAME_BYTES_DEF,
	parameter int AW = $clog2(WINDOW_DEPTH)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          frame_mode,
	input  logic          in_valid,
	input  logic          opcode,
	input  logic [7:0]    data_byte,
	output logic          busy,
	input  logic          out_free,
	output logic          emit_valid,
	output emit_t         emit,
	output logic          mem_we,
	output logic [AW-1:0] mem_waddr,
	output logic [7:0]    mem_wdata,
	output logic          mem_re,
	output logic [AW-1:0] mem_raddr,
	input  logic [7:0]    mem_rdata
);

	localparam int FW = $clog2(WINDOW_DEPTH + 1);
	localparam int SW = AW + 1;
	localparam int CW = FW + 1;
	localparam int JW = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
	localparam int DH_MID_POS  = 2 + FRAME_BYTES;
	localparam int DH_FULL_LEN = DH_MID_POS + 2 + DH_TAIL;

	typedef enum logic [5:0] {
		ST_IDLE      = 6'b000001,
		ST_APPEND    = 6'b000010,
		ST_REQ       = 6'b000100,
		ST_CMP       = 6'b001000,
		ST_EMIT_REQ  = 6'b010000,
		ST_EMIT_LOAD = 6'b100000
	} state_t;

	// which window byte the scan looks at next
	typedef enum logic [2:0] {
		CK_H0 = 3'd0,
		CK_H1 = 3'd1,
		CK_E0 = 3'd2,
		CK_E1 = 3'd3,
		CK_M0 = 3'd4,
		CK_M1 = 3'd5
	} chk_t;

	state_t         state_q;
	chk_t           step_q;
	logic [AW-1:0]  head_q;
	logic [FW-1:0]  fill_q;
	logic [7:0]     byte_q;
	logic [JW-1:0]  j_q;
	logic [AW-1:0]  emit_off_q;

	logic [CW-1:0]  need;
	logic [AW-1:0]  chk_off;
	logic [7:0]     head0_exp;
	logic [7:0]     head1_exp;
	logic           full;
	logic           have_need;
	logic           last_byte;
	logic [CW-1:0]  fill_c;

	function automatic logic [AW-1:0] wrap(input logic [SW-1:0] v);
		logic [SW-1:0] r;
		r = v;
		if (v >= SW'(WINDOW_DEPTH)) begin
			r = v - SW'(WINDOW_DEPTH);
		end
		return r[AW-1:0];
	endfunction

	function automatic logic [AW-1:0] add_head(input logic [AW-1:0] h,
			input logic [SW-1:0] n);
		return wrap(SW'(h) + n);
	endfunction

	assign fill_c    = CW'(fill_q);
	assign full      = (CW'(fill_q) == CW'(WINDOW_DEPTH));
	assign have_need = (fill_c >= need);
	assign last_byte = (j_q == JW'(FRAME_BYTES - 1));
	assign head0_exp = (frame_mode == MODE_DUAL) ? DH_HEAD0 : SH_HEAD0;
	assign head1_exp = (frame_mode == MODE_DUAL) ? DH_HEAD1 : SH_HEAD1;

	always_comb begin
		unique case (step_q)
			CK_H0: begin
				need = CW'(1);
				chk_off = '0;
			end
			CK_H1: begin
				need = CW'(2);
				chk_off = AW'(1);
			end
			CK_E0: begin
				need = CW'(4);
				chk_off = AW'(2);
			end
			CK_E1: begin
				need = CW'(4);
				chk_off = AW'(3);
			end
			CK_M0: begin
				need = CW'(DH_MID_POS + 2);
				chk_off = AW'(DH_MID_POS);
			end
			CK_M1: begin
				need = CW'(DH_MID_POS + 2);
				chk_off = AW'(DH_MID_POS + 1);
			end
			default: begin
				need = CW'(1);
				chk_off = '0;
			end
		endcase
	end

	assign busy = (state_q != ST_IDLE);

	assign mem_we    = (state_q == ST_APPEND);
	assign mem_wdata = byte_q;
	// a full window overwrites its oldest slot
	assign mem_waddr = full ? head_q : add_head(head_q, SW'(fill_q));
	assign mem_re    = (state_q == ST_REQ) || (state_q == ST_EMIT_REQ);
	assign mem_raddr = (state_q == ST_REQ) ? add_head(head_q, SW'(chk_off))
		: add_head(head_q, SW'(emit_off_q + AW'(j_q)));

	assign emit_valid       = (state_q == ST_EMIT_LOAD) && out_free;
	assign emit.frame_byte  = mem_rdata;
	assign emit.byte_index  = IDX_W'(j_q);
	assign emit.last        = last_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			step_q     <= CK_H0;
			head_q     <= '0;
			fill_q     <= '0;
			j_q        <= '0;
			emit_off_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						if (opcode == OP_RESYNC) begin
							head_q <= '0;
							fill_q <= '0;
						end else begin
							state_q <= ST_APPEND;
						end
					end
				end
				ST_APPEND: begin
					if (full) begin
						head_q <= add_head(head_q, SW'(1));
					end else begin
						fill_q <= fill_q + FW'(1);
					end
					step_q  <= CK_H0;
					state_q <= ST_REQ;
				end
				ST_REQ: begin
					state_q <= have_need ? ST_CMP : ST_IDLE;
				end
				ST_CMP: begin
					state_q <= ST_REQ;
					unique case (step_q)
						CK_H0: begin
							if (mem_rdata != head0_exp) begin
								head_q <= add_head(head_q, SW'(1));
								fill_q <= fill_q - FW'(1);
							end else begin
								step_q <= CK_H1;
							end
						end
						CK_H1: begin
							if (mem_rdata != head1_exp) begin
								head_q <= add_head(head_q, SW'(1));
								fill_q <= fill_q - FW'(1);
								step_q <= CK_H0;
							end else if (frame_mode == MODE_DUAL) begin
								step_q <= CK_E0;
							end else if (fill_c < CW'(FRAME_BYTES)) begin
								state_q <= ST_IDLE;
							end else begin
								j_q        <= '0;
								emit_off_q <= '0;
								state_q    <= ST_EMIT_REQ;
							end
						end
						CK_E0: begin
							step_q <= (mem_rdata == DH_MID0) ? CK_E1 : CK_M0;
						end
						CK_E1: begin
							if (mem_rdata != DH_MID1) begin
								step_q <= CK_M0;
							end else if (fill_c < CW'(DH_EMPTY_LEN)) begin
								state_q <= ST_IDLE;
							end else begin
								// empty packet, dropped without output
								head_q <= add_head(head_q, SW'(DH_EMPTY_LEN));
								fill_q <= fill_q - FW'(DH_EMPTY_LEN);
								step_q <= CK_H0;
							end
						end
						CK_M0: begin
							if (mem_rdata != DH_MID0) begin
								head_q <= add_head(head_q, SW'(1));
								fill_q <= fill_q - FW'(1);
								step_q <= CK_H0;
							end else begin
								step_q <= CK_M1;
							end
						end
						CK_M1: begin
							if (mem_rdata != DH_MID1) begin
								head_q <= add_head(head_q, SW'(1));
								fill_q <= fill_q - FW'(1);
								step_q <= CK_H0;
							end else if (fill_c < CW'(DH_FULL_LEN)) begin
								state_q <= ST_IDLE;
							end else begin
								j_q        <= '0;
								emit_off_q <= AW'(2);
								state_q    <= ST_EMIT_REQ;
							end
						end
						default: begin
							step_q <= CK_H0;
						end
					endcase
				end
				ST_EMIT_REQ: begin
					state_q <= ST_EMIT_LOAD;
				end
				ST_EMIT_LOAD: begin
					if (out_free) begin
						if (last_byte) begin
							if (frame_mode == MODE_DUAL) begin
								head_q <= add_head(head_q, SW'(DH_FULL_LEN));
								fill_q <= fill_q - FW'(DH_FULL_LEN);
							end else begin
								head_q <= add_head(head_q, SW'(FRAME_BYTES));
								fill_q <= fill_q - FW'(FRAME_BYTES);
							end
							state_q <= ST_IDLE;
						end else begin
							j_q     <= j_q + JW'(1);
							state_q <= ST_EMIT_REQ;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// received byte waits here for its write slot
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid && opcode == OP_DATA) begin
			byte_q <= data_byte;
		end
	end

endmodule

// File: tb/header_sync_frame_extractor_core_test.sv
// self-checking regression bench for the header sync frame extractor core
`timescale 1ns / 1ps

import hsfe_pkg::*;

localparam int PKT_MID_POS = 2 + FRAME_BYTES_DEF;
localparam int PKT_LEN     = PKT_MID_POS + 2 + DH_TAIL;

class deframer_scoreboard;
	logic [7:0]  window [WINDOW_DEPTH_DEF];
	int unsigned head;
	int unsigned fill;
	logic        mode;
	emit_t       expected_bytes[$];
	int          mismatches;
	int          bytes_checked;
	int          frames_checked;

	function new();
		head = 0;
		fill = 0;
		mode = MODE_SINGLE;
		mismatches = 0;
		bytes_checked = 0;
		frames_checked = 0;
	endfunction

	function void set_mode(logic m);
		mode = m;
	endfunction

	function int pending();
		return expected_bytes.size();
	endfunction

	function logic [7:0] peek(int unsigned k);
		return window[(head + k) % WINDOW_DEPTH_DEF];
	endfunction

	function void drop(int unsigned n);
		if (n > fill)
			n = fill;
		head = (head + n) % WINDOW_DEPTH_DEF;
		fill = fill - n;
	endfunction

	function void queue_frame(int unsigned off);
		emit_t e;
		for (int j = 0; j < FRAME_BYTES_DEF; j++) begin
			e.frame_byte = peek(off + j);
			e.byte_index = j[IDX_W-1:0];
			e.last       = (j == FRAME_BYTES_DEF - 1);
			expected_bytes.push_back(e);
		end
	endfunction

	// resync empties the window; data is appended, scanned until it waits or emits
	function void note_byte(logic op, logic [7:0] b);
		logic [7:0] h0;
		logic [7:0] h1;
		if (op == OP_RESYNC) begin
			head = 0;
			fill = 0;
			return;
		end
		if (fill >= WINDOW_DEPTH_DEF)
			drop(1);
		window[(head + fill) % WINDOW_DEPTH_DEF] = b;
		fill++;
		while (fill != 0) begin
			h0 = (mode == MODE_SINGLE) ? SH_HEAD0 : DH_HEAD0;
			h1 = (mode == MODE_SINGLE) ? SH_HEAD1 : DH_HEAD1;
			if (peek(0) != h0) begin
				drop(1);
				continue;
			end
			if (fill < 2)
				return;
			if (peek(1) != h1) begin
				drop(1);
				continue;
			end
			if (mode == MODE_SINGLE) begin
				if (fill < FRAME_BYTES_DEF)
					return;
				queue_frame(0);
				drop(FRAME_BYTES_DEF);
				return;
			end
			if (fill < 4)
				return;
			// empty packet: mid marker right behind the header
			if (peek(2) == DH_MID0 && peek(3) == DH_MID1) begin
				if (fill < DH_EMPTY_LEN)
					return;
				drop(DH_EMPTY_LEN);
				continue;
			end
			if (fill < PKT_MID_POS + 2)
				return;
			if (peek(PKT_MID_POS) != DH_MID0 || peek(PKT_MID_POS + 1) != DH_MID1) begin
				drop(1);
				continue;
			end
			if (fill < PKT_LEN)
				return;
			queue_frame(2);
			drop(PKT_LEN);
			return;
		end
	endfunction

	function void check_frame_byte(logic [7:0] fb, logic [IDX_W-1:0] idx, logic lst);
		emit_t want;
		emit_t got;
		got.frame_byte = fb;
		got.byte_index = idx;
		got.last       = lst;
		if (expected_bytes.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected frame byte %02h index %0d last %0d", fb, idx, lst);
			return;
		end
		want = expected_bytes.pop_front();
		bytes_checked++;
		if (want !== got) begin
			mismatches++;
			if (mismatches <= 10)
				$display("frame byte mismatch: expected %02h index %0d last %0d, got %02h index %0d last %0d",
					want.frame_byte, want.byte_index, want.last, fb, idx, lst);
		end else if (lst) begin
			frames_checked++;
		end
	endfunction
endclass

module header_sync_frame_extractor_core_test;

	localparam int SETTLE_CYCLES  = 800;
	localparam int LONG_HOLD      = 2000;
	localparam int WATCHDOG_LIMIT = 20000;

	typedef enum int {FK_GOOD, FK_EMPTY, FK_BAD_MID, FK_CUT} frame_kind_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_we = 1'b0;
	logic             cfg_wdata = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_stall;
	logic             opcode = OP_DATA;
	logic [7:0]       data_byte = 8'h00;
	logic             out_valid;
	logic             out_stall = 1'b0;
	logic [7:0]       frame_byte;
	logic [IDX_W-1:0] byte_index;
	logic             last;

	deframer_scoreboard sb = new();

	int burst_left = 0;
	int n_items = 0;
	int n_resyncs = 0;
	int n_cfg_writes = 0;
	int n_holds = 0;
	bit hold_req = 0;
	int hold_cnt = 0;
	int stall_run = 0;
	int stall_pct = 0;
	int idle_cycles = 0;

	header_sync_frame_extractor_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.opcode     (opcode),
		.data_byte  (data_byte),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.frame_byte (frame_byte),
		.byte_index (byte_index),
		.last       (last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// offer one item and hold it until taken; bursts end in a random gap
	task automatic send_item(input logic op, input logic [7:0] b);
		in_valid  <= 1'b1;
		opcode    <= op;
		data_byte <= b;
		do @(posedge clk); while (in_stall);
		sb.note_byte(op, b);
		n_items++;
		if (op == OP_RESYNC)
			n_resyncs++;
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
			burst_left = ($urandom_range(3) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
		end
	endtask

	task automatic send_data(input logic [7:0] b);
		send_item(OP_DATA, b);
	endtask

	task automatic send_frame(input logic m, input frame_kind_t kind);
		logic [7:0] seq[$];
		int cut;
		if (m == MODE_SINGLE) begin
			seq.push_back(SH_HEAD0);
			seq.push_back(SH_HEAD1);
			repeat (FRAME_BYTES_DEF - 2) seq.push_back(8'($urandom));
			if (kind == FK_BAD_MID)
				seq[1] = seq[1] ^ 8'($urandom_range(1, 255));
		end else begin
			seq.push_back(DH_HEAD0);
			seq.push_back(DH_HEAD1);
			if (kind == FK_EMPTY) begin
				seq.push_back(DH_MID0);
				seq.push_back(DH_MID1);
			end else begin
				repeat (FRAME_BYTES_DEF) seq.push_back(8'($urandom));
				seq.push_back(DH_MID0);
				seq.push_back(DH_MID1);
				if (kind == FK_BAD_MID)
					seq[PKT_MID_POS + $urandom_range(1)] ^= 8'($urandom_range(1, 255));
			end
			repeat (DH_TAIL) seq.push_back(8'($urandom));
		end
		if (kind == FK_CUT) begin
			cut = $urandom_range(1, seq.size() - 1);
			while (seq.size() > cut)
				void'(seq.pop_back());
		end
		foreach (seq[i])
			send_data(seq[i]);
		if (kind == FK_CUT && $urandom_range(1) == 1)
			send_item(OP_RESYNC, 8'($urandom));
	endtask

	// let the block drain its frames and finish any scan before touching the register
	task automatic settle();
		if (in_valid)
			in_valid <= 1'b0;
		while (in_stall)
			@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_mode(input logic m);
		settle();
		cfg_we    <= 1'b1;
		cfg_wdata <= m;
		@(posedge clk);
		sb.set_mode(m);
		cfg_we <= 1'b0;
		n_cfg_writes++;
	endtask

	task automatic random_phase(input int target);
		int start;
		int pick;
		start = n_items;
		while (n_items - start < target) begin
			pick = $urandom_range(99);
			if (pick < 60) begin
				if (sb.mode == MODE_DUAL && $urandom_range(3) == 0)
					send_frame(sb.mode, FK_EMPTY);
				else
					send_frame(sb.mode, FK_GOOD);
			end else if (pick < 80) begin
				send_frame(sb.mode, ($urandom_range(1) == 0) ? FK_BAD_MID : FK_CUT);
			end else if (pick < 95) begin
				repeat ($urandom_range(1, 6)) send_data(8'($urandom));
			end else begin
				send_item(OP_RESYNC, 8'($urandom));
			end
		end
	endtask

	// receiver: random stall stretches, plus one long hold-off on request
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_frame_byte(frame_byte, byte_index, last);
		if (hold_req && hold_cnt == 0) begin
			hold_req = 0;
			hold_cnt = LONG_HOLD;
			n_holds++;
		end
		if (hold_cnt != 0) begin
			hold_cnt--;
			out_stall <= 1'b1;
		end else begin
			if (stall_run == 0) begin
				case ($urandom_range(2))
					0: stall_pct = 0;
					1: stall_pct = 25;
					default: stall_pct = 60;
				endcase
				stall_run = $urandom_range(20, 200);
			end
			stall_run--;
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no item moved for %0d cycles, %0d frame bytes outstanding",
				idle_cycles, sb.pending());
			$display("header_sync_frame_extractor_core regression: fail");
			$finish;
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_mode(MODE_SINGLE);

		// single header: stray bytes, broken header, doubled first header byte
		send_data(8'h00);
		send_data(8'hFF);
		send_data(SH_HEAD1);
		send_data(SH_HEAD0);
		send_data(8'h00);
		send_data(SH_HEAD0);
		// long output hold-off while a frame completes, so the input backs up
		hold_req = 1;
		send_frame(MODE_SINGLE, FK_GOOD);
		// resync in the middle of a frame and on an empty window
		repeat (6) send_data(8'($urandom));
		send_data(SH_HEAD0);
		send_data(SH_HEAD1);
		repeat (6) send_data(8'($urandom));
		send_item(OP_RESYNC, 8'h00);
		send_item(OP_RESYNC, 8'hFF);

		write_mode(MODE_DUAL);
		send_frame(MODE_DUAL, FK_EMPTY);
		send_frame(MODE_DUAL, FK_GOOD);
		send_frame(MODE_DUAL, FK_BAD_MID);
		send_data(DH_HEAD0);
		send_data(8'h00);
		// short empty packet cut off by a resync
		send_data(DH_HEAD0);
		send_data(DH_HEAD1);
		send_data(DH_MID0);
		send_data(DH_MID1);
		repeat (5) send_data(8'($urandom));
		send_item(OP_RESYNC, 8'($urandom));

		// mode switches with bytes still held in the window
		send_data(DH_HEAD0);
		send_data(DH_HEAD1);
		repeat (6) send_data(8'($urandom));
		write_mode(MODE_SINGLE);
		send_frame(MODE_SINGLE, FK_GOOD);
		send_data(DH_HEAD0);
		send_data(DH_HEAD1);
		send_data(SH_HEAD0);
		send_data(SH_HEAD1);
		write_mode(MODE_DUAL);
		send_frame(MODE_DUAL, FK_EMPTY);

		for (int ph = 0; ph < 2; ph++) begin
			write_mode(ph[0] ? MODE_DUAL : MODE_SINGLE);
			random_phase(25);
		end

		settle();
		$display("%0d input items sent (%0d resyncs), %0d mode writes, %0d long output hold-offs",
			n_items, n_resyncs, n_cfg_writes, n_holds);
		$display("%0d frame bytes checked in %0d frames, %0d mismatches",
			sb.bytes_checked, sb.frames_checked, sb.mismatches);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("header_sync_frame_extractor_core regression: pass");
		else
			$display("header_sync_frame_extractor_core regression: fail");
		$finish;
	end

endmodule
